FILE: hdl/spa_pkg.sv
// shared types, codes and constants of the shared pll port allocator
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  localparam int unsigned PORT_COUNT = 8;
  localparam int unsigned PLL_NUM    = 4;

  localparam logic [1:0] KIND_MAP   = 2'd0;
  localparam logic [1:0] KIND_UNMAP = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PLL   = 2'd1;
  localparam logic [1:0] ST_BAD_RATE = 2'd2;
  localparam logic [1:0] ST_NO_LOCK  = 2'd3;

  localparam logic [12:0] RATE_1620 = 13'd1620;
  localparam logic [12:0] RATE_2160 = 13'd2160;
  localparam logic [12:0] RATE_2700 = 13'd2700;
  localparam logic [12:0] RATE_3240 = 13'd3240;
  localparam logic [12:0] RATE_4320 = 13'd4320;
  localparam logic [12:0] RATE_5400 = 13'd5400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  port;
    logic        is_edp;
    logic        is_hdmi;
    logic [12:0] dp_rate_mhz;
    logic [15:0] dco_int;
    logic [15:0] dco_frac;
    logic [39:0] divisors;
    logic        lock_ok;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] pll;
    logic       needs_reset;
    logic       pll_released;
    logic [3:0] pll_enables;
  } res_t;

  function automatic logic rate_valid(input logic [12:0] rate);
    rate_valid = (rate == RATE_1620) || (rate == RATE_2160) || (rate == RATE_2700) ||
                 (rate == RATE_3240) || (rate == RATE_4320) || (rate == RATE_5400);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/spa_core.sv
// allocation state and the single pass that maps, unmaps and queries one request
`timescale 1ns / 1ps
`default_nettype none

module spa_core
  import spa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  wire req_t req,
  output res_t      res
);

  logic        mapped_r  [PORT_COUNT];
  logic [1:0]  port_pll_r[PORT_COUNT];
  logic [3:0]  cnt_r     [PLL_NUM];
  logic [3:0]  en_r;
  logic        set_hdmi_r[PLL_NUM];
  logic [12:0] set_rate_r[PLL_NUM];
  logic [31:0] set_dco_r [PLL_NUM];
  logic [39:0] set_div_r [PLL_NUM];

  logic        mapped_nxt  [PORT_COUNT];
  logic [1:0]  port_pll_nxt[PORT_COUNT];
  logic [3:0]  cnt_nxt     [PLL_NUM];
  logic [3:0]  en_nxt;

  logic [3:0]  cnt_rel[PLL_NUM];
  logic [3:0]  en_rel;
  logic [3:0]  match;
  logic [3:0]  avail;
  logic [31:0] req_dco;
  logic        in_range;
  logic        cur_mapped;
  logic [1:0]  cur_pll;
  logic        rel_do;
  logic        rel_zero;
  logic        found;
  logic [1:0]  pick;
  logic        set_wr;

  assign req_dco    = {req.dco_int, req.dco_frac};
  assign in_range   = (5'(req.port) < 5'(PORT_COUNT));
  assign cur_mapped = in_range && mapped_r[req.port];
  assign cur_pll    = port_pll_r[req.port];
  assign rel_do     = cur_mapped;

  // setting compare against each pll
  always_comb begin
    for (int i = 0; i < PLL_NUM; i++) begin
      if (set_hdmi_r[i] != req.is_hdmi) begin
        match[i] = 1'b0;
      end else if (req.is_hdmi) begin
        match[i] = (set_dco_r[i] == req_dco) && (set_div_r[i] == req.divisors);
      end else begin
        match[i] = (set_rate_r[i] == req.dp_rate_mhz);
      end
    end
  end

  // counts and enables after releasing the port's old pll
  always_comb begin
    for (int i = 0; i < PLL_NUM; i++) begin
      cnt_rel[i] = cnt_r[i];
    end
    en_rel   = en_r;
    rel_zero = 1'b0;
    if (rel_do && (cnt_r[cur_pll] != 4'd0)) begin
      cnt_rel[cur_pll] = cnt_r[cur_pll] - 4'd1;
      if (cnt_r[cur_pll] == 4'd1) begin
        rel_zero = 1'b1;
        if (cur_pll != 2'd0) begin
          en_rel[cur_pll] = 1'b0;
        end
      end
    end
  end

  // pll search: pll0 for embedded ports, else pll1, pll3, pll2
  always_comb begin
    for (int i = 0; i < PLL_NUM; i++) begin
      avail[i] = (cnt_rel[i] == 4'd0) || match[i];
    end
    found = 1'b0;
    pick  = 2'd0;
    if (req.is_edp) begin
      found = avail[0];
      pick  = 2'd0;
    end else if (avail[1]) begin
      found = 1'b1;
      pick  = 2'd1;
    end else if (avail[3]) begin
      found = 1'b1;
      pick  = 2'd3;
    end else if (avail[2]) begin
      found = 1'b1;
      pick  = 2'd2;
    end
    found = found && in_range;
  end

  always_comb begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      mapped_nxt[i]   = mapped_r[i];
      port_pll_nxt[i] = port_pll_r[i];
    end
    for (int i = 0; i < PLL_NUM; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    en_nxt           = en_r;
    set_wr           = 1'b0;
    res.status       = ST_OK;
    res.pll          = 2'd0;
    res.needs_reset  = 1'b0;
    res.pll_released = 1'b0;
    case (req.kind)
      KIND_MAP: begin
        if (in_range) begin
          mapped_nxt[req.port] = 1'b0;
          for (int i = 0; i < PLL_NUM; i++) begin
            cnt_nxt[i] = cnt_rel[i];
          end
          en_nxt = en_rel;
        end
        if (!found) begin
          res.status = ST_NO_PLL;
        end else begin
          res.pll = pick;
          if ((cnt_rel[pick] == 4'd0) && !req.is_hdmi && !rate_valid(req.dp_rate_mhz)) begin
            res.status = ST_BAD_RATE;
          end else if ((cnt_rel[pick] == 4'd0) && !req.lock_ok) begin
            res.status = ST_NO_LOCK;
          end else begin
            if (cnt_rel[pick] == 4'd0) begin
              en_nxt[pick] = 1'b1;
              set_wr       = 1'b1;
            end
            cnt_nxt[pick]          = cnt_rel[pick] + 4'd1;
            mapped_nxt[req.port]   = 1'b1;
            port_pll_nxt[req.port] = pick;
          end
        end
      end
      KIND_UNMAP: begin
        if (rel_do) begin
          res.pll              = cur_pll;
          res.pll_released     = rel_zero;
          mapped_nxt[req.port] = 1'b0;
          for (int i = 0; i < PLL_NUM; i++) begin
            cnt_nxt[i] = cnt_rel[i];
          end
          en_nxt = en_rel;
        end
      end
      KIND_QUERY: begin
        if (cur_mapped) begin
          res.pll         = cur_pll;
          res.needs_reset = !match[cur_pll];
        end else begin
          res.needs_reset = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.pll_enables = en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        mapped_r[i]   <= 1'b0;
        port_pll_r[i] <= 2'd0;
      end
      for (int i = 0; i < PLL_NUM; i++) begin
        cnt_r[i] <= 4'd0;
      end
      en_r <= 4'd0;
    end else if (fire) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        mapped_r[i]   <= mapped_nxt[i];
        port_pll_r[i] <= port_pll_nxt[i];
      end
      for (int i = 0; i < PLL_NUM; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      en_r <= en_nxt;
    end
  end

  // pll settings, written when a free pll is started
  always_ff @(posedge clk) begin
    if (fire && set_wr) begin
      set_hdmi_r[pick] <= req.is_hdmi;
      if (req.is_hdmi) begin
        set_dco_r[pick] <= req_dco;
        set_div_r[pick] <= req.divisors;
      end else begin
        set_rate_r[pick] <= req.dp_rate_mhz;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/shared_pll_port_allocator.sv
// Shared PLL port allocator: hands four PLLs (clock sources) to display ports with use counts.
// Each request word (map, unmap or needs-reset query) is captured in an input register,
// resolved against the allocation state, and its answer is held in an output register, so
// one word is taken every clock while in_stall is low and the answer word is presented
// from the output register. A stall on the output side backs up into in_stall only once
// both registers are full. Every request gives exactly one answer word.
`timescale 1ns / 1ps
`default_nettype none

module shared_pll_port_allocator
  import spa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_port,
  input  wire logic        in_is_edp,
  input  wire logic        in_is_hdmi,
  input  wire logic [12:0] in_dp_rate_mhz,
  input  wire logic [15:0] in_dco_int,
  input  wire logic [15:0] in_dco_frac,
  input  wire logic [39:0] in_divisors,
  input  wire logic        in_lock_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [1:0]       out_pll,
  output logic             out_needs_reset,
  output logic             out_pll_released,
  output logic [3:0]       out_pll_enables
);

  logic s1_valid_r;
  req_t s1_req_r;
  logic out_valid_r;
  res_t out_res_r;
  res_t core_res;
  logic s1_go;
  logic fire;

  assign s1_go    = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r.kind        <= in_kind;
      s1_req_r.port        <= in_port;
      s1_req_r.is_edp      <= in_is_edp;
      s1_req_r.is_hdmi     <= in_is_hdmi;
      s1_req_r.dp_rate_mhz <= in_dp_rate_mhz;
      s1_req_r.dco_int     <= in_dco_int;
      s1_req_r.dco_frac    <= in_dco_frac;
      s1_req_r.divisors    <= in_divisors;
      s1_req_r.lock_ok     <= in_lock_ok;
    end
  end

  spa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_req_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_pll          = out_res_r.pll;
  assign out_needs_reset  = out_res_r.needs_reset;
  assign out_pll_released = out_res_r.pll_released;
  assign out_pll_enables  = out_res_r.pll_enables;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench of the shared pll port allocator, random and directed requests
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import spa_pkg::*;

  class pll_alloc_tracker;
    bit          port_mapped [PORT_COUNT];
    logic [1:0]  port_pll    [PORT_COUNT];
    logic [3:0]  pll_users   [PLL_NUM];
    logic        pll_hdmi    [PLL_NUM];
    logic [12:0] pll_rate    [PLL_NUM];
    logic [31:0] pll_dco     [PLL_NUM];
    logic [39:0] pll_div     [PLL_NUM];
    logic [3:0]  enables;
    int          search_order [3];
    res_t        answers_due [$];
    int          errors;
    int          answered;

    function new();
      foreach (port_mapped[i]) begin
        port_mapped[i] = 1'b0;
        port_pll[i]    = '0;
      end
      foreach (pll_users[i]) begin
        pll_users[i] = '0;
        pll_hdmi[i]  = 1'b0;
        pll_rate[i]  = '0;
        pll_dco[i]   = '0;
        pll_div[i]   = '0;
      end
      search_order[0] = 1;
      search_order[1] = 3;
      search_order[2] = 2;
      enables  = '0;
      errors   = 0;
      answered = 0;
    endfunction

    function bit good_rate(logic [12:0] rate);
      case (rate)
        RATE_1620, RATE_2160, RATE_2700, RATE_3240, RATE_4320, RATE_5400: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit same_setting(int p, req_t w);
      if (pll_hdmi[p] != w.is_hdmi) return 1'b0;
      if (w.is_hdmi)
        return pll_dco[p] == {w.dco_int, w.dco_frac} && pll_div[p] == w.divisors;
      return pll_rate[p] == w.dp_rate_mhz;
    endfunction

    // drops a port's mapping, true when its pll went unused
    function bit drop_port(int port);
      int p;
      bit zero;
      p = int'(port_pll[port]);
      zero = 1'b0;
      if (!port_mapped[port]) return 1'b0;
      port_mapped[port] = 1'b0;
      if (pll_users[p] != 0) begin
        pll_users[p] = pll_users[p] - 4'd1;
        if (pll_users[p] == 0) begin
          zero = 1'b1;
          if (p != 0) enables[p] = 1'b0;
        end
      end
      return zero;
    endfunction

    function void note_request(req_t w);
      res_t a;
      int   chosen;
      a = '0;
      chosen = -1;
      case (w.kind)
        KIND_MAP: begin
          if (w.port < PORT_COUNT) begin
            void'(drop_port(int'(w.port)));
            if (w.is_edp) begin
              if (pll_users[0] == 0 || same_setting(0, w)) chosen = 0;
            end else begin
              foreach (search_order[i]) begin
                if (chosen < 0 && (pll_users[search_order[i]] == 0 ||
                                   same_setting(search_order[i], w)))
                  chosen = search_order[i];
              end
            end
          end
          if (chosen < 0) begin
            a.status = ST_NO_PLL;
          end else begin
            a.pll = 2'(chosen);
            if (pll_users[chosen] == 0) begin
              if (!w.is_hdmi && !good_rate(w.dp_rate_mhz)) begin
                a.status = ST_BAD_RATE;
              end else if (!w.lock_ok) begin
                a.status = ST_NO_LOCK;
              end else begin
                enables[chosen]  = 1'b1;
                pll_hdmi[chosen] = w.is_hdmi;
                if (w.is_hdmi) begin
                  pll_dco[chosen] = {w.dco_int, w.dco_frac};
                  pll_div[chosen] = w.divisors;
                end else begin
                  pll_rate[chosen] = w.dp_rate_mhz;
                end
              end
            end
            if (a.status == ST_OK) begin
              pll_users[chosen]   = pll_users[chosen] + 4'd1;
              port_mapped[w.port] = 1'b1;
              port_pll[w.port]    = 2'(chosen);
            end
          end
        end
        KIND_UNMAP: begin
          if (w.port < PORT_COUNT && port_mapped[w.port]) begin
            a.pll = port_pll[w.port];
            a.pll_released = drop_port(int'(w.port));
          end
        end
        KIND_QUERY: begin
          if (w.port < PORT_COUNT && port_mapped[w.port]) begin
            a.pll = port_pll[w.port];
            a.needs_reset = !same_setting(int'(port_pll[w.port]), w);
          end else begin
            a.needs_reset = 1'b1;
          end
        end
        default: begin
        end
      endcase
      a.pll_enables = enables;
      answers_due.push_back(a);
    endfunction

    task report(string what, int got, int want);
      if (errors < 100)
        $display("mismatch at answer %0d: %s got %0d want %0d", answered, what, got, want);
      errors++;
    endtask

    task check_answer(res_t got);
      res_t want;
      if (answers_due.size() == 0) begin
        report("answer with nothing pending", int'(got), 0);
        return;
      end
      want = answers_due.pop_front();
      if (got.status != want.status)
        report("status", int'(got.status), int'(want.status));
      if (got.pll != want.pll) report("pll", int'(got.pll), int'(want.pll));
      if (got.needs_reset != want.needs_reset)
        report("needs_reset", int'(got.needs_reset), int'(want.needs_reset));
      if (got.pll_released != want.pll_released)
        report("pll_released", int'(got.pll_released), int'(want.pll_released));
      if (got.pll_enables != want.pll_enables)
        report("pll_enables", int'(got.pll_enables), int'(want.pll_enables));
      answered++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [2:0]  in_port;
  logic        in_is_edp;
  logic        in_is_hdmi;
  logic [12:0] in_dp_rate_mhz;
  logic [15:0] in_dco_int;
  logic [15:0] in_dco_frac;
  logic [39:0] in_divisors;
  logic        in_lock_ok;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [1:0]  out_pll;
  logic        out_needs_reset;
  logic        out_pll_released;
  logic [3:0]  out_pll_enables;

  pll_alloc_tracker tracker;
  logic [31:0]      dco_pool [3];
  logic [39:0]      div_pool [3];
  req_t             opening [$];
  int               calm_in;
  int               calm_out;
  int               stall_left;

  shared_pll_port_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_port          (in_port),
    .in_is_edp        (in_is_edp),
    .in_is_hdmi       (in_is_hdmi),
    .in_dp_rate_mhz   (in_dp_rate_mhz),
    .in_dco_int       (in_dco_int),
    .in_dco_frac      (in_dco_frac),
    .in_divisors      (in_divisors),
    .in_lock_ok       (in_lock_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_pll          (out_pll),
    .out_needs_reset  (out_needs_reset),
    .out_pll_released (out_pll_released),
    .out_pll_enables  (out_pll_enables)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t make_req(logic [1:0] kind, int port, int edp,
                                    int hdmi, logic [12:0] rate, logic [31:0] dco,
                                    logic [39:0] div, int lock);
    req_t w;
    w.kind        = kind;
    w.port        = 3'(port);
    w.is_edp      = 1'(edp);
    w.is_hdmi     = 1'(hdmi);
    w.dp_rate_mhz = rate;
    w.dco_int     = dco[31:16];
    w.dco_frac    = dco[15:0];
    w.divisors    = div;
    w.lock_ok     = 1'(lock);
    return w;
  endfunction

  function automatic logic [12:0] valid_rate();
    case ($urandom_range(0, 5))
      0: return RATE_1620;
      1: return RATE_2160;
      2: return RATE_2700;
      3: return RATE_3240;
      4: return RATE_4320;
      default: return RATE_5400;
    endcase
  endfunction

  // mostly well-formed requests over a small set of settings so that sharing happens
  function automatic req_t random_req();
    req_t w;
    int   r;
    int   k;
    r = $urandom_range(0, 99);
    w.kind = r < 45 ? KIND_MAP : r < 70 ? KIND_UNMAP : r < 95 ? KIND_QUERY : KIND_RSVD;
    w.port = 3'($urandom_range(0, 7));
    w.is_edp = $urandom_range(0, 99) < 15;
    w.is_hdmi = $urandom_range(0, 99) < 35;
    w.dp_rate_mhz = $urandom_range(0, 99) < 85 ? valid_rate() : 13'($urandom);
    k = $urandom_range(0, 2);
    if ($urandom_range(0, 99) < 80) begin
      {w.dco_int, w.dco_frac} = dco_pool[k];
      w.divisors = div_pool[k];
    end else begin
      {w.dco_int, w.dco_frac} = $urandom;
      w.divisors = {8'($urandom), 32'($urandom)};
    end
    w.lock_ok = $urandom_range(0, 99) < 90;
    return w;
  endfunction

  task automatic drive_request(req_t w);
    int gap;
    if (calm_in > 0) begin
      calm_in--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 99) == 0) calm_in = $urandom_range(50, 150);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= w.kind;
    in_port        <= w.port;
    in_is_edp      <= w.is_edp;
    in_is_hdmi     <= w.is_hdmi;
    in_dp_rate_mhz <= w.dp_rate_mhz;
    in_dco_int     <= w.dco_int;
    in_dco_frac    <= w.dco_frac;
    in_divisors    <= w.divisors;
    in_lock_ok     <= w.lock_ok;
    do @(posedge clk); while (in_stall);
    tracker.note_request(w);
  endtask

  // result side: check accepted words, then choose the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_answer({out_status, out_pll, out_needs_reset, out_pll_released,
                            out_pll_enables});
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_out > 0) begin
      calm_out--;
      out_stall <= 1'b0;
    end else begin
      stall_left = idle_len();
      if ($urandom_range(0, 99) == 0) calm_out = $urandom_range(50, 150);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    tracker    = new();
    calm_in    = 0;
    calm_out   = 0;
    stall_left = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    out_stall      <= 1'b0;
    in_kind        <= '0;
    in_port        <= '0;
    in_is_edp      <= 1'b0;
    in_is_hdmi     <= 1'b0;
    in_dp_rate_mhz <= '0;
    in_dco_int     <= '0;
    in_dco_frac    <= '0;
    in_divisors    <= '0;
    in_lock_ok     <= 1'b0;
    foreach (dco_pool[i]) begin
      dco_pool[i] = $urandom;
      div_pool[i] = {8'($urandom), 32'($urandom)};
    end

    // empty ports, plls filling up, sharing, failures, releases
    opening.push_back(make_req(KIND_QUERY, 0, 0, 0, RATE_1620, '0, '0, 1));
    opening.push_back(make_req(KIND_UNMAP, 1, 0, 0, '0, '0, '0, 0));
    opening.push_back(make_req(KIND_MAP, 0, 0, 0, RATE_1620, '0, '0, 1));
    opening.push_back(make_req(KIND_MAP, 1, 0, 0, RATE_1620, '0, '0, 0));
    opening.push_back(make_req(KIND_MAP, 2, 0, 0, RATE_5400, '0, '0, 1));
    opening.push_back(make_req(KIND_MAP, 3, 0, 1, '0, '1, '1, 1));
    opening.push_back(make_req(KIND_MAP, 4, 0, 0, RATE_2700, '0, '0, 1));
    opening.push_back(make_req(KIND_MAP, 5, 1, 0, RATE_2160, '0, '0, 0));
    opening.push_back(make_req(KIND_MAP, 5, 1, 0, '1, '0, '0, 1));
    opening.push_back(make_req(KIND_MAP, 5, 1, 1, '0, '0, '0, 1));
    opening.push_back(make_req(KIND_QUERY, 5, 1, 1, '0, '0, '0, 1));
    opening.push_back(make_req(KIND_QUERY, 5, 1, 0, RATE_2160, '0, '0, 1));
    opening.push_back(make_req(KIND_QUERY, 0, 0, 0, RATE_1620, '1, '1, 0));
    opening.push_back(make_req(KIND_QUERY, 3, 0, 1, '0, '1, 40'hFF_FFFF_FFFE, 1));
    opening.push_back(make_req(KIND_UNMAP, 0, 0, 0, '0, '0, '0, 0));
    opening.push_back(make_req(KIND_UNMAP, 1, 0, 0, '0, '0, '0, 0));
    opening.push_back(make_req(KIND_MAP, 6, 0, 0, '0, '0, '0, 1));
    opening.push_back(make_req(KIND_UNMAP, 5, 1, 0, '0, '0, '0, 0));
    opening.push_back(make_req(KIND_RSVD, 7, 1, 1, '1, '1, '1, 1));
    opening.push_back(make_req(KIND_MAP, 2, 0, 0, RATE_3240, '0, '0, 1));
    opening.push_back(make_req(KIND_MAP, 7, 0, 0, RATE_4320, '0, '0, 1));
    opening.push_back(make_req(KIND_UNMAP, 3, 0, 0, '0, '0, '0, 0));
    opening.push_back(make_req(KIND_MAP, 4, 0, 1, '0, '1, '1, 1));
    opening.push_back(make_req(KIND_QUERY, 7, 0, 0, RATE_4320, '0, '0, 1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) drive_request(opening[i]);
    repeat (1450 - opening.size()) drive_request(random_req());
    in_valid <= 1'b0;

    while (tracker.answers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.answers_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
